/* rtl/spq_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spq_pkg
// Shared types and constants for the sorted priority queue.
// ----------------------------------------------------------------------------
package spq_pkg;

  localparam int DEPTH_DEF = 16;
  localparam int VAL_W     = 32;
  localparam int PRIO_W    = 16;
  localparam int OCC_W     = 5;
  localparam int STAT_W    = 3;
  localparam int OP_W      = 2;

  typedef enum logic [OP_W-1:0] {
    OP_ENQ  = 2'd0,
    OP_DEQ  = 2'd1,
    OP_TRAV = 2'd2
  } op_t;

  typedef enum logic [STAT_W-1:0] {
    ST_ENQ   = 3'd0,
    ST_DEQ   = 3'd1,
    ST_FULL  = 3'd2,
    ST_EMPTY = 3'd3,
    ST_TRAV  = 3'd4
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_ENQ_CMP,
    S_ENQ_INS,
    S_DEQ_HEAD,
    S_DEQ_SHIFT,
    S_TRV,
    S_RESP
  } state_t;

  typedef struct packed {
    logic [VAL_W-1:0]  value;
    logic [PRIO_W-1:0] prio;
  } entry_t;

endpackage

/* rtl/sorted_priority_queue_core.sv */
`timescale 1ns / 1ps
// Enqueue: lower-priority entries (up to occupancy) move down; the new entry goes in.
// Dequeue: the head is read, then the rest shift up.
// Traverse: one result per cycle while out_ready is high.
// Full or empty rejects give a status result. Unused op code: accepted, no result.
// Rate is set by the single storage write port and the one priority comparator.
// Synchronous reset empties the queue; storage contents are not cleared.
// ----------------------------------------------------------------------------
// sorted_priority_queue_core
// Bounded priority queue kept sorted, highest priority first, FIFO on ties.
// ----------------------------------------------------------------------------
module sorted_priority_queue_core #(
  parameter int DEPTH = spq_pkg::DEPTH_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [spq_pkg::OP_W-1:0]          in_op,
  input  logic signed [spq_pkg::VAL_W-1:0]  in_value,
  input  logic signed [spq_pkg::PRIO_W-1:0] in_priority_req,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [spq_pkg::STAT_W-1:0]        out_status,
  output logic signed [spq_pkg::VAL_W-1:0]  out_value,
  output logic signed [spq_pkg::PRIO_W-1:0] out_priority,
  output logic [spq_pkg::OCC_W-1:0]         out_occupancy,
  output logic                              out_last
);

  localparam int AW = $clog2(DEPTH);

  logic            mem_we;
  logic [AW-1:0]   mem_waddr;
  spq_pkg::entry_t mem_wdata;
  logic [AW-1:0]   mem_raddr;
  spq_pkg::entry_t mem_rdata;

  spq_ctrl #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_ctrl (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_op           (in_op),
    .in_value        (in_value),
    .in_priority_req (in_priority_req),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_status      (out_status),
    .out_value       (out_value),
    .out_priority    (out_priority),
    .out_occupancy   (out_occupancy),
    .out_last        (out_last),
    .mem_we          (mem_we),
    .mem_waddr       (mem_waddr),
    .mem_wdata       (mem_wdata),
    .mem_raddr       (mem_raddr),
    .mem_rdata       (mem_rdata)
  );

  spq_mem #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

endmodule

/* rtl/spq_mem.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spq_mem
// Entry storage: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module spq_mem #(
  parameter int DEPTH = spq_pkg::DEPTH_DEF,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic            clk,
  input  logic            we,
  input  logic [AW-1:0]   waddr,
  input  spq_pkg::entry_t wdata,
  input  logic [AW-1:0]   raddr,
  output spq_pkg::entry_t rdata
);

  spq_pkg::entry_t mem_r [DEPTH];
  spq_pkg::entry_t rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

/* rtl/spq_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spq_ctrl
// Sequencer: walks the entry storage one slot per cycle (traverse steps
// stall on out_ready) via one priority comparator; holds the result register.
// ----------------------------------------------------------------------------
module spq_ctrl #(
  parameter int DEPTH = spq_pkg::DEPTH_DEF,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [spq_pkg::OP_W-1:0]          in_op,
  input  logic signed [spq_pkg::VAL_W-1:0]  in_value,
  input  logic signed [spq_pkg::PRIO_W-1:0] in_priority_req,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [spq_pkg::STAT_W-1:0]        out_status,
  output logic signed [spq_pkg::VAL_W-1:0]  out_value,
  output logic signed [spq_pkg::PRIO_W-1:0] out_priority,
  output logic [spq_pkg::OCC_W-1:0]         out_occupancy,
  output logic                              out_last,
  output logic                              mem_we,
  output logic [AW-1:0]                     mem_waddr,
  output spq_pkg::entry_t                   mem_wdata,
  output logic [AW-1:0]                     mem_raddr,
  input  spq_pkg::entry_t                   mem_rdata
);

  localparam int CW = $clog2(DEPTH + 1);

  spq_pkg::state_t  state_r, state_nxt;
  logic [CW-1:0]    cnt_r, cnt_nxt;
  logic [AW-1:0]    pos_r, pos_nxt;
  logic [AW-1:0]    idx_r, idx_nxt;
  spq_pkg::entry_t  new_r, new_nxt;
  spq_pkg::status_t res_status_r, res_status_nxt;
  spq_pkg::entry_t  res_entry_r, res_entry_nxt;

  logic                     out_valid_r, out_valid_nxt;
  spq_pkg::status_t         out_status_r;
  spq_pkg::entry_t          out_entry_r;
  logic [spq_pkg::OCC_W-1:0] out_occ_r;
  logic                     out_last_r;

  logic             out_free;
  logic             load;
  spq_pkg::status_t ld_status;
  spq_pkg::entry_t  ld_entry;
  logic             ld_last;
  logic             full;
  logic             prio_lt;
  logic [CW+4:0]    cnt_ext;

  assign out_free = !out_valid_r || out_ready;
  assign full     = (cnt_r == CW'(DEPTH));
  // single comparator: stored priority below the new one
  assign prio_lt  = $signed(mem_rdata.prio) < $signed(new_r.prio);
  assign cnt_ext  = {5'd0, cnt_r};

  always_comb begin
    state_nxt      = state_r;
    cnt_nxt        = cnt_r;
    pos_nxt        = pos_r;
    idx_nxt        = idx_r;
    new_nxt        = new_r;
    res_status_nxt = res_status_r;
    res_entry_nxt  = res_entry_r;
    in_ready       = 1'b0;
    mem_we         = 1'b0;
    mem_waddr      = pos_r;
    mem_wdata      = new_r;
    mem_raddr      = idx_r;
    load           = 1'b0;
    ld_status      = res_status_r;
    ld_entry       = res_entry_r;
    ld_last        = 1'b1;

    case (state_r)
      spq_pkg::S_IDLE: begin
        in_ready  = 1'b1;
        mem_raddr = (in_op == spq_pkg::OP_ENQ) ? (cnt_r[AW-1:0] - AW'(1)) : '0;
        idx_nxt   = '0;
        if (in_valid) begin
          res_entry_nxt = '0;
          case (in_op)
            spq_pkg::OP_ENQ: begin
              new_nxt = {in_value, in_priority_req};
              pos_nxt = cnt_r[AW-1:0];
              if (full) begin
                res_status_nxt = spq_pkg::ST_FULL;
                state_nxt      = spq_pkg::S_RESP;
              end else if (cnt_r == '0) begin
                state_nxt = spq_pkg::S_ENQ_INS;
              end else begin
                state_nxt = spq_pkg::S_ENQ_CMP;
              end
            end
            spq_pkg::OP_DEQ: begin
              if (cnt_r == '0) begin
                res_status_nxt = spq_pkg::ST_EMPTY;
                state_nxt      = spq_pkg::S_RESP;
              end else begin
                state_nxt = spq_pkg::S_DEQ_HEAD;
              end
            end
            spq_pkg::OP_TRAV: begin
              if (cnt_r == '0) begin
                res_status_nxt = spq_pkg::ST_EMPTY;
                state_nxt      = spq_pkg::S_RESP;
              end else begin
                state_nxt = spq_pkg::S_TRV;
              end
            end
            default: ;
          endcase
        end
      end

      spq_pkg::S_ENQ_CMP: begin
        mem_we    = 1'b1;
        mem_waddr = pos_r;
        mem_raddr = pos_r - AW'(2);
        if (prio_lt) begin
          mem_wdata = mem_rdata;
          pos_nxt   = pos_r - AW'(1);
          if (pos_r == AW'(1)) begin
            state_nxt = spq_pkg::S_ENQ_INS;
          end
        end else begin
          mem_wdata      = new_r;
          cnt_nxt        = cnt_r + CW'(1);
          res_status_nxt = spq_pkg::ST_ENQ;
          state_nxt      = spq_pkg::S_RESP;
        end
      end

      spq_pkg::S_ENQ_INS: begin
        mem_we         = 1'b1;
        mem_waddr      = pos_r;
        mem_wdata      = new_r;
        cnt_nxt        = cnt_r + CW'(1);
        res_status_nxt = spq_pkg::ST_ENQ;
        state_nxt      = spq_pkg::S_RESP;
      end

      spq_pkg::S_DEQ_HEAD: begin
        res_status_nxt = spq_pkg::ST_DEQ;
        res_entry_nxt  = mem_rdata;
        mem_raddr      = AW'(1);
        idx_nxt        = '0;
        if (cnt_r == CW'(1)) begin
          cnt_nxt   = cnt_r - CW'(1);
          state_nxt = spq_pkg::S_RESP;
        end else begin
          state_nxt = spq_pkg::S_DEQ_SHIFT;
        end
      end

      spq_pkg::S_DEQ_SHIFT: begin
        mem_we    = 1'b1;
        mem_waddr = idx_r;
        mem_wdata = mem_rdata;
        mem_raddr = idx_r + AW'(2);
        idx_nxt   = idx_r + AW'(1);
        if ((CW'(idx_r) + CW'(2)) >= cnt_r) begin
          cnt_nxt   = cnt_r - CW'(1);
          state_nxt = spq_pkg::S_RESP;
        end
      end

      spq_pkg::S_TRV: begin
        mem_raddr = idx_r;
        ld_status = spq_pkg::ST_TRAV;
        ld_entry  = mem_rdata;
        ld_last   = (CW'(idx_r) + CW'(1)) == cnt_r;
        if (out_free) begin
          load = 1'b1;
          if (ld_last) begin
            state_nxt = spq_pkg::S_IDLE;
          end else begin
            idx_nxt   = idx_r + AW'(1);
            mem_raddr = idx_r + AW'(1);
          end
        end
      end

      spq_pkg::S_RESP: begin
        if (out_free) begin
          load      = 1'b1;
          state_nxt = spq_pkg::S_IDLE;
        end
      end

      default: state_nxt = spq_pkg::S_IDLE;
    endcase

    out_valid_nxt = load ? 1'b1 : (out_ready ? 1'b0 : out_valid_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= spq_pkg::S_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pos_r        <= pos_nxt;
    idx_r        <= idx_nxt;
    new_r        <= new_nxt;
    res_status_r <= res_status_nxt;
    res_entry_r  <= res_entry_nxt;
    if (load) begin
      out_status_r <= ld_status;
      out_entry_r  <= ld_entry;
      out_occ_r    <= cnt_ext[spq_pkg::OCC_W-1:0];
      out_last_r   <= ld_last;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_status    = out_status_r;
  assign out_value     = out_entry_r.value;
  assign out_priority  = out_entry_r.prio;
  assign out_occupancy = out_occ_r;
  assign out_last      = out_last_r;

endmodule

/* bench/sorted_priority_queue_core_test.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_priority_queue_core_test
// Self-checking bench for the sorted priority queue. A queue-fed driver and a
// clocked monitor exercise enqueue, dequeue and traverse against a scoreboard
// that keeps its own sorted copy of the entries and predicts every result.
// ----------------------------------------------------------------------------
module sorted_priority_queue_core_test;

  localparam int QDEPTH       = spq_pkg::DEPTH_DEF;
  localparam int HOLD_CYCLES  = 300;
  localparam int STALL_LIMIT  = 5000;
  localparam int DRAIN_CYCLES = 64;
  localparam int CALM_TAIL    = 30;
  localparam logic [spq_pkg::OP_W-1:0] OP_UNUSED = 2'd3;

  typedef struct {
    logic [spq_pkg::OP_W-1:0]          op;
    logic signed [spq_pkg::VAL_W-1:0]  value;
    logic signed [spq_pkg::PRIO_W-1:0] prio;
  } queue_cmd_t;

  typedef struct {
    logic [spq_pkg::STAT_W-1:0]        status;
    logic signed [spq_pkg::VAL_W-1:0]  value;
    logic signed [spq_pkg::PRIO_W-1:0] prio;
    logic [spq_pkg::OCC_W-1:0]         occ;
    logic                              last;
  } queue_resp_t;

  logic                              clk = 1'b0;
  logic                              rst_n = 1'b0;
  logic                              in_valid = 1'b0;
  logic                              in_ready;
  logic [spq_pkg::OP_W-1:0]          in_op = '0;
  logic signed [spq_pkg::VAL_W-1:0]  in_value = '0;
  logic signed [spq_pkg::PRIO_W-1:0] in_priority_req = '0;
  logic                              out_valid;
  logic                              out_ready = 1'b0;
  logic [spq_pkg::STAT_W-1:0]        out_status;
  logic signed [spq_pkg::VAL_W-1:0]  out_value;
  logic signed [spq_pkg::PRIO_W-1:0] out_priority;
  logic [spq_pkg::OCC_W-1:0]         out_occupancy;
  logic                              out_last;

  queue_cmd_t  pending_q[$];
  queue_resp_t resp_q[$];

  logic signed [spq_pkg::VAL_W-1:0]  model_val[QDEPTH];
  logic signed [spq_pkg::PRIO_W-1:0] model_pri[QDEPTH];
  int model_count = 0;
  int plan_count = 0;

  bit in_took = 1'b0;
  bit final_phase = 1'b0;
  bit long_hold_req = 1'b0;
  bit long_hold_done = 1'b0;
  int hold_cnt = 0;
  int tx_gap = 0;
  int rx_gap = 0;
  int idle_cycles = 0;

  int mismatches = 0;
  int n_in = 0;
  int n_out = 0;
  int n_full = 0;
  int n_empty = 0;
  int peak_occ = 0;

  sorted_priority_queue_core dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_op           (in_op),
    .in_value        (in_value),
    .in_priority_req (in_priority_req),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_status      (out_status),
    .out_value       (out_value),
    .out_priority    (out_priority),
    .out_occupancy   (out_occupancy),
    .out_last        (out_last)
  );

  always #5 clk = ~clk;

  // Sorted shadow of the queue; ties go behind existing equal priorities.
  task automatic predict_queue_op(input queue_cmd_t c);
    int pos;
    queue_resp_t r;
    r.value  = '0;
    r.prio   = '0;
    r.last   = 1'b1;
    r.status = spq_pkg::ST_ENQ;
    case (c.op)
      spq_pkg::OP_ENQ: begin
        if (model_count >= QDEPTH) begin
          r.status = spq_pkg::ST_FULL;
          n_full++;
        end else begin
          pos = model_count;
          while (pos > 0 && model_pri[pos-1] < c.prio) begin
            model_val[pos] = model_val[pos-1];
            model_pri[pos] = model_pri[pos-1];
            pos--;
          end
          model_val[pos] = c.value;
          model_pri[pos] = c.prio;
          model_count++;
          r.status = spq_pkg::ST_ENQ;
        end
        r.occ = spq_pkg::OCC_W'(model_count);
        resp_q.push_back(r);
      end
      spq_pkg::OP_DEQ: begin
        if (model_count == 0) begin
          r.status = spq_pkg::ST_EMPTY;
          n_empty++;
        end else begin
          r.status = spq_pkg::ST_DEQ;
          r.value  = model_val[0];
          r.prio   = model_pri[0];
          for (pos = 0; pos + 1 < model_count; pos++) begin
            model_val[pos] = model_val[pos+1];
            model_pri[pos] = model_pri[pos+1];
          end
          model_count--;
        end
        r.occ = spq_pkg::OCC_W'(model_count);
        resp_q.push_back(r);
      end
      spq_pkg::OP_TRAV: begin
        r.occ = spq_pkg::OCC_W'(model_count);
        if (model_count == 0) begin
          r.status = spq_pkg::ST_EMPTY;
          n_empty++;
          resp_q.push_back(r);
        end else begin
          for (pos = 0; pos < model_count; pos++) begin
            r.status = spq_pkg::ST_TRAV;
            r.value  = model_val[pos];
            r.prio   = model_pri[pos];
            r.last   = (pos == model_count - 1);
            resp_q.push_back(r);
          end
        end
      end
      default: ;
    endcase
    if (model_count > peak_occ) peak_occ = model_count;
  endtask

  function automatic queue_cmd_t make_cmd(input logic [spq_pkg::OP_W-1:0] op,
                                          input logic signed [spq_pkg::VAL_W-1:0] v,
                                          input logic signed [spq_pkg::PRIO_W-1:0] p);
    queue_cmd_t c;
    c.op    = op;
    c.value = v;
    c.prio  = p;
    return c;
  endfunction

  // Runs of mostly-fill, mostly-drain or mixed traffic so the queue swings
  // between empty and full; priorities often collide to exercise ties.
  task automatic plan_random(input int n);
    int made;
    int mode;
    int left;
    int pick;
    queue_cmd_t c;
    made = 0;
    mode = 0;
    left = 0;
    while (made < n) begin
      if (left == 0) begin
        mode = $urandom_range(0, 2);
        left = $urandom_range(6, 20);
      end
      pick = $urandom_range(0, 99);
      c.value = $urandom;
      if ($urandom_range(0, 1) == 1) c.prio = spq_pkg::PRIO_W'($urandom);
      else c.prio = spq_pkg::PRIO_W'(int'($urandom_range(0, 4)) - 2);
      if (pick < 3) c.op = OP_UNUSED;
      else if (pick < 11) c.op = spq_pkg::OP_TRAV;
      else if (mode == 0) c.op = (pick < 80) ? spq_pkg::OP_ENQ : spq_pkg::OP_DEQ;
      else if (mode == 1) c.op = (pick < 80) ? spq_pkg::OP_DEQ : spq_pkg::OP_ENQ;
      else c.op = (pick < 55) ? spq_pkg::OP_ENQ : spq_pkg::OP_DEQ;
      pending_q.push_back(c);
      if (c.op != OP_UNUSED) made++;
      left--;
    end
  endtask

  task automatic wait_drained();
    while (pending_q.size() != 0 || in_valid || resp_q.size() != 0) @(posedge clk);
  endtask

  // Sender: one item in flight, random gap bursts between transfers.
  always @(negedge clk) begin
    queue_cmd_t cmd;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_took) begin
      if (in_took && tx_gap == 0 && !(final_phase && pending_q.size() <= CALM_TAIL) &&
          $urandom_range(0, 3) == 0)
        tx_gap = $urandom_range(1, 6);
      if (tx_gap > 0) begin
        in_valid <= 1'b0;
        tx_gap--;
      end else if (pending_q.size() > 0) begin
        cmd = pending_q.pop_front();
        in_valid        <= 1'b1;
        in_op           <= cmd.op;
        in_value        <= cmd.value;
        in_priority_req <= cmd.prio;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver: random stall bursts, one long hold-off on request.
  always @(negedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (long_hold_req && !long_hold_done) begin
      out_ready <= 1'b0;
      hold_cnt++;
      if (hold_cnt >= HOLD_CYCLES) long_hold_done = 1'b1;
    end else if (final_phase && pending_q.size() <= CALM_TAIL) begin
      out_ready <= 1'b1;
    end else if (rx_gap > 0) begin
      out_ready <= 1'b0;
      rx_gap--;
    end else if ($urandom_range(0, 4) == 0) begin
      out_ready <= 1'b0;
      rx_gap = $urandom_range(0, 5);
    end else begin
      out_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    queue_cmd_t  got_cmd;
    queue_resp_t want;
    if (!rst_n) begin
      in_took <= 1'b0;
    end else begin
      in_took <= in_valid && in_ready;
      if (in_valid && in_ready) begin
        n_in++;
        got_cmd = make_cmd(in_op, in_value, in_priority_req);
        predict_queue_op(got_cmd);
      end
      if (out_valid && out_ready) begin
        n_out++;
        if (resp_q.size() == 0) begin
          $error("unexpected result transfer: status %0d value %0d priority %0d",
                 out_status, out_value, out_priority);
          mismatches++;
        end else begin
          want = resp_q.pop_front();
          if (out_status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, out_status);
            mismatches++;
          end
          if (out_value !== want.value) begin
            $error("out_value: expected %0d, got %0d", want.value, out_value);
            mismatches++;
          end
          if (out_priority !== want.prio) begin
            $error("out_priority: expected %0d, got %0d", want.prio, out_priority);
            mismatches++;
          end
          if (out_occupancy !== want.occ) begin
            $error("occupancy: expected %0d, got %0d", want.occ, out_occupancy);
            mismatches++;
          end
          if (out_last !== want.last) begin
            $error("last: expected %0d, got %0d", want.last, out_last);
            mismatches++;
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("timeout: no transfer for %0d cycles, %0d results outstanding",
               idle_cycles, resp_q.size());
      $display("== FAIL ==");
      $finish;
    end
  end

  initial begin
    int k;
    logic signed [spq_pkg::PRIO_W-1:0] p;
    rst_n = 1'b0;
    repeat (4) @(posedge clk);
    @(negedge clk) rst_n = 1'b1;

    // directed: empty cases, extremes, ties, unused code, fill to full
    pending_q.push_back(make_cmd(spq_pkg::OP_DEQ, 32'sd7, 16'sd3));
    pending_q.push_back(make_cmd(spq_pkg::OP_TRAV, 32'sd0, 16'sd0));
    pending_q.push_back(make_cmd(spq_pkg::OP_ENQ, 32'sh7fffffff, 16'sh7fff));
    pending_q.push_back(make_cmd(spq_pkg::OP_ENQ, 32'sh80000000, 16'sh8000));
    pending_q.push_back(make_cmd(spq_pkg::OP_ENQ, 32'sd0, 16'sd0));
    pending_q.push_back(make_cmd(spq_pkg::OP_ENQ, -32'sd1, -16'sd1));
    pending_q.push_back(make_cmd(spq_pkg::OP_ENQ, 32'sd12345, 16'sd0));
    pending_q.push_back(make_cmd(OP_UNUSED, 32'shffffffff, 16'shffff));
    pending_q.push_back(make_cmd(spq_pkg::OP_TRAV, 32'sd0, 16'sd0));
    pending_q.push_back(make_cmd(spq_pkg::OP_DEQ, 32'sd0, 16'sd0));
    for (k = 0; k < 12; k++) begin
      p = (k % 3 == 0) ? 16'sd0 : ((k % 3 == 1) ? 16'sh7fff : 16'sh8000);
      pending_q.push_back(make_cmd(spq_pkg::OP_ENQ,
                                   spq_pkg::VAL_W'(k * 32'h1111_1111 + k), p));
    end
    pending_q.push_back(make_cmd(spq_pkg::OP_ENQ, 32'sh5a5a5a5a, 16'sh7fff));
    pending_q.push_back(make_cmd(spq_pkg::OP_TRAV, 32'sd0, 16'sd0));
    pending_q.push_back(make_cmd(spq_pkg::OP_DEQ, 32'sd0, 16'sd0));
    wait_drained();

    // receiver holds off while the sender keeps offering
    long_hold_req = 1'b1;
    plan_random(40);
    while (!long_hold_done) @(posedge clk);
    wait_drained();

    final_phase = 1'b1;
    plan_random(95);
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Checked %0d results from %0d operations; peak occupancy %0d,",
             n_out, n_in, peak_occ);
    $display("full rejects %0d, empty responses %0d, mismatches %0d.",
             n_full, n_empty, mismatches);
    if (mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

/* files.f */
rtl/spq_pkg.sv
rtl/spq_mem.sv
rtl/spq_ctrl.sv
rtl/sorted_priority_queue_core.sv
bench/sorted_priority_queue_core_test.sv
